// ===== design/motion_keyframe_selector_assert.svh =====
`ifndef MOTION_KEYFRAME_SELECTOR_ASSERT_SVH
`define MOTION_KEYFRAME_SELECTOR_ASSERT_SVH

// check that cond implies res on the same edge
`define MKS_ASSERT_SAME(label, clk, rst_n, cond, res) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (res)) \
    else $error("motion_keyframe_selector: same-cycle check failed");

// check that cond implies res on the next edge
`define MKS_ASSERT_NEXT(label, clk, rst_n, cond, res) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (res)) \
    else $error("motion_keyframe_selector: next-cycle check failed");

`endif

// ===== design/mks_pkg.sv =====
package mks_pkg;

  localparam int MAX_PIXELS = 262144;
  localparam int ADDR_W     = $clog2(MAX_PIXELS);
  localparam int ACNT_W     = ADDR_W + 1;

  localparam int PIX_W      = 8;
  localparam int CNT_W      = 19;
  localparam int TIME_W     = 24;
  localparam int STEP_W     = 10;
  localparam int LIM_W      = 16;
  localparam int KIND_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 19;

  localparam logic [CNT_W-1:0]  CNT_MAX     = '1;
  localparam logic [TIME_W-1:0] TIME_MAX    = '1;
  localparam logic [STEP_W-1:0] COARSE_STEP = 10'd100;
  localparam logic [TIME_W:0]   MIN_GAP     = 25'd2;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QLVL_W = $clog2(QDEPTH + 1);

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE      = 3'd0,
    KIND_INITIAL   = 3'd1,
    KIND_PRE_SPIKE = 3'd2,
    KIND_LEADING   = 3'd3,
    KIND_BURST     = 3'd4,
    KIND_SETTLED   = 3'd5
  } emit_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIFF_THRESHOLD = 3'd0,
    CFG_STILL_LIMIT    = 3'd1,
    CFG_SPIKE_LIMIT    = 3'd2,
    CFG_FINE_STEP      = 3'd3,
    CFG_COARSE_DELAY   = 3'd4,
    CFG_BURST_CAP      = 3'd5,
    CFG_SETTLE         = 3'd6
  } cfg_index_t;

  typedef struct packed {
    logic [PIX_W-1:0]  diff_threshold;
    logic [CNT_W-1:0]  still_count_limit;
    logic [CNT_W-1:0]  spike_count_limit;
    logic [STEP_W-1:0] fine_step_cs;
    logic [LIM_W-1:0]  coarse_delay_cs;
    logic [LIM_W-1:0]  burst_cap_cs;
    logic [LIM_W-1:0]  settle_cs;
  } cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0]  count;
    logic              prev_valid;
    logic              fresh;
    logic [TIME_W-1:0] frame_time;
  } frame_word_t;

  typedef struct packed {
    logic [QLVL_W-1:0] level;
    logic              full;
  } q_status_t;

endpackage

// ===== design/mks_if.sv =====
interface mks_in_if;
  logic                              valid;
  logic                              ready;
  logic [mks_pkg::PIX_W-1:0]         pixel;
  logic                              last_pixel;
  logic                              new_chunk;
  logic [mks_pkg::TIME_W-1:0]        frame_time_cs;

  modport source (output valid, pixel, last_pixel, new_chunk, frame_time_cs, input ready);
  modport sink (input valid, pixel, last_pixel, new_chunk, frame_time_cs, output ready);
endinterface

interface mks_out_if;
  logic                              valid;
  logic                              ready;
  logic [mks_pkg::KIND_W-1:0]        emit_kind;
  logic [mks_pkg::TIME_W-1:0]        emit_time_cs;
  logic [mks_pkg::STEP_W-1:0]        next_step_cs;
  logic [mks_pkg::CNT_W-1:0]         changed_count;
  logic                              motion_seen;
  logic                              spike_seen;

  modport source (output valid, emit_kind, emit_time_cs, next_step_cs, changed_count,
                  motion_seen, spike_seen, input ready);
  modport sink (input valid, emit_kind, emit_time_cs, next_step_cs, changed_count,
                motion_seen, spike_seen, output ready);
endinterface

// ===== design/motion_keyframe_selector.sv =====
// Motion keyframe selector: takes one grayscale pixel word per cycle in raster order
// while ready is high, diffs it against the frame store and counts changed pixels, and
// on each frame's last pixel returns one result word with the frame class, the keyframe
// decision and the next scan step. The frame store (262144 entries) is read and written
// at the same address once per cycle, which sets that rate. With the output free, a
// result word is valid once its last pixel has passed the compare stage, a queue slot
// and the output register. Up to four finished frames queue between the pixel path and
// the decision logic so either side can stall alone; the input stalls only while four
// frames wait in the queue or are on their way into it. Configuration words are taken at
// any edge with cfg_we high and should only be written while the block is idle.
module motion_keyframe_selector (
  input  logic                              clk,
  input  logic                              rst_n,
  mks_in_if.sink                            in_ch,
  mks_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [mks_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mks_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  mks_pkg::cfg_t        cfg_r;
  mks_pkg::q_status_t   q_status;
  mks_pkg::frame_word_t push_word;
  mks_pkg::frame_word_t head_word;
  logic                 push;
  logic                 pop;
  logic                 head_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.diff_threshold    <= 8'd25;
      cfg_r.still_count_limit <= 19'd1310;
      cfg_r.spike_count_limit <= 19'd11796;
      cfg_r.fine_step_cs      <= 10'd10;
      cfg_r.coarse_delay_cs   <= 16'd300;
      cfg_r.burst_cap_cs      <= 16'd100;
      cfg_r.settle_cs         <= 16'd30;
    end else if (cfg_we) begin
      unique case (mks_pkg::cfg_index_t'(cfg_index))
        mks_pkg::CFG_DIFF_THRESHOLD: cfg_r.diff_threshold    <= cfg_wdata[mks_pkg::PIX_W-1:0];
        mks_pkg::CFG_STILL_LIMIT:    cfg_r.still_count_limit <= cfg_wdata[mks_pkg::CNT_W-1:0];
        mks_pkg::CFG_SPIKE_LIMIT:    cfg_r.spike_count_limit <= cfg_wdata[mks_pkg::CNT_W-1:0];
        mks_pkg::CFG_FINE_STEP:      cfg_r.fine_step_cs      <= cfg_wdata[mks_pkg::STEP_W-1:0];
        mks_pkg::CFG_COARSE_DELAY:   cfg_r.coarse_delay_cs   <= cfg_wdata[mks_pkg::LIM_W-1:0];
        mks_pkg::CFG_BURST_CAP:      cfg_r.burst_cap_cs      <= cfg_wdata[mks_pkg::LIM_W-1:0];
        mks_pkg::CFG_SETTLE:         cfg_r.settle_cs         <= cfg_wdata[mks_pkg::LIM_W-1:0];
        default: begin
          // drop writes to unused indexes
        end
      endcase
    end
  end

  mks_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .diff_threshold (cfg_r.diff_threshold),
    .q_status       (q_status),
    .push           (push),
    .push_word      (push_word)
  );

  mks_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_word  (push_word),
    .pop        (pop),
    .head_valid (head_valid),
    .head_word  (head_word),
    .status     (q_status)
  );

  mks_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_valid (head_valid),
    .head_word  (head_word),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

// ===== design/mks_front.sv =====
module mks_front (
  input  logic                         clk,
  input  logic                         rst_n,
  mks_in_if.sink                       in_ch,
  input  logic [mks_pkg::PIX_W-1:0]    diff_threshold,
  input  mks_pkg::q_status_t           q_status,
  output logic                         push,
  output mks_pkg::frame_word_t         push_word
);

  logic [mks_pkg::PIX_W-1:0] frame_mem [mks_pkg::MAX_PIXELS];

  logic [mks_pkg::ACNT_W-1:0] addr_r, addr_nxt;
  logic                       pv_r, pv_nxt;
  logic                       frame_fresh_r, frame_fresh_nxt;

  logic                       s1_valid_r;
  logic                       s1_cmp_r;
  logic                       s1_last_r;
  logic                       s1_pv_r;
  logic                       s1_fresh_r;
  logic [mks_pkg::PIX_W-1:0]  s1_px_r;
  logic [mks_pkg::PIX_W-1:0]  old_r;
  logic [mks_pkg::TIME_W-1:0] s1_time_r;
  logic [mks_pkg::CNT_W-1:0]  cnt_r, cnt_nxt, cnt_inc;

  logic                       accept;
  logic                       first;
  logic                       pv_eff;
  logic                       in_range;
  logic                       fresh_eff;
  logic [mks_pkg::PIX_W-1:0]  diff;
  logic [mks_pkg::QLVL_W:0]   committed;

  assign committed   = {1'b0, q_status.level} + (mks_pkg::QLVL_W + 1)'(s1_valid_r & s1_last_r);
  assign in_ch.ready = committed < (mks_pkg::QLVL_W + 1)'(mks_pkg::QDEPTH);
  assign accept      = in_ch.valid & in_ch.ready;

  assign first     = (addr_r == '0);
  assign pv_eff    = (first && in_ch.new_chunk) ? 1'b0 : pv_r;
  assign in_range  = addr_r < mks_pkg::ACNT_W'(mks_pkg::MAX_PIXELS);
  assign fresh_eff = first ? in_ch.new_chunk : frame_fresh_r;

  always_comb begin
    addr_nxt        = addr_r;
    pv_nxt          = pv_r;
    frame_fresh_nxt = frame_fresh_r;
    if (accept) begin
      frame_fresh_nxt = fresh_eff;
      if (in_ch.last_pixel) begin
        addr_nxt = '0;
        pv_nxt   = 1'b1;
      end else begin
        pv_nxt = pv_eff;
        if (in_range) begin
          addr_nxt = addr_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_range) begin
      old_r <= frame_mem[addr_r[mks_pkg::ADDR_W-1:0]];
      frame_mem[addr_r[mks_pkg::ADDR_W-1:0]] <= in_ch.pixel;
    end
  end

  assign diff = (s1_px_r > old_r) ? s1_px_r - old_r : old_r - s1_px_r;

  always_comb begin
    cnt_inc = cnt_r;
    if (s1_cmp_r && diff > diff_threshold && cnt_r != mks_pkg::CNT_MAX) begin
      cnt_inc = cnt_r + 1'b1;
    end
    cnt_nxt = cnt_r;
    if (s1_valid_r) begin
      cnt_nxt = s1_last_r ? '0 : cnt_inc;
    end
  end

  assign push                 = s1_valid_r & s1_last_r;
  assign push_word.count      = cnt_inc;
  assign push_word.prev_valid = s1_pv_r;
  assign push_word.fresh      = s1_fresh_r;
  assign push_word.frame_time = s1_time_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r        <= '0;
      pv_r          <= 1'b0;
      frame_fresh_r <= 1'b0;
      s1_valid_r    <= 1'b0;
      cnt_r         <= '0;
    end else begin
      addr_r        <= addr_nxt;
      pv_r          <= pv_nxt;
      frame_fresh_r <= frame_fresh_nxt;
      s1_valid_r    <= accept;
      cnt_r         <= cnt_nxt;
    end
    if (accept) begin
      s1_cmp_r   <= in_range & pv_eff;
      s1_last_r  <= in_ch.last_pixel;
      s1_pv_r    <= pv_eff;
      s1_fresh_r <= fresh_eff;
      s1_px_r    <= in_ch.pixel;
      s1_time_r  <= in_ch.frame_time_cs;
    end
  end

endmodule

// ===== design/mks_queue.sv =====
module mks_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  mks_pkg::frame_word_t  push_word,
  input  logic                  pop,
  output logic                  head_valid,
  output mks_pkg::frame_word_t  head_word,
  output mks_pkg::q_status_t    status
);

  mks_pkg::frame_word_t slot_r [mks_pkg::QDEPTH];

  logic [mks_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [mks_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [mks_pkg::QLVL_W-1:0] level_r, level_nxt;
  logic                       do_push, do_pop;

  assign status.level = level_r;
  assign status.full  = (level_r == mks_pkg::QLVL_W'(mks_pkg::QDEPTH));
  assign head_valid   = (level_r != '0);
  assign head_word    = slot_r[rd_ptr_r];

  assign do_push = push & ~status.full;
  assign do_pop  = pop & head_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    level_nxt  = level_r;
    if (do_push && !do_pop) begin
      level_nxt = level_r + 1'b1;
    end else if (do_pop && !do_push) begin
      level_nxt = level_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_word;
    end
  end

endmodule

// ===== design/mks_back.sv =====
module mks_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mks_pkg::cfg_t         cfg,
  input  logic                  head_valid,
  input  mks_pkg::frame_word_t  head_word,
  output logic                  pop,
  mks_out_if.source             out_ch
);

  logic                       initial_done_r, initial_done_nxt;
  logic                       motion_pending_r, motion_pending_nxt;
  logic [mks_pkg::TIME_W-1:0] last_emit_r, last_emit_nxt;
  logic [mks_pkg::TIME_W-1:0] prev_time_r;
  logic [mks_pkg::TIME_W-1:0] quiet_r, quiet_nxt;
  logic [mks_pkg::TIME_W-1:0] settle_r, settle_nxt;

  logic                       out_valid_r;
  mks_pkg::emit_kind_t        kind_r, kind_nxt;
  logic [mks_pkg::TIME_W-1:0] etime_r, etime_nxt;
  logic [mks_pkg::STEP_W-1:0] step_r, step_nxt;
  logic [mks_pkg::CNT_W-1:0]  count_r;
  logic                       motion_r, spike_r;

  logic                       id, mp;
  logic [mks_pkg::TIME_W-1:0] last_e, pt, qt, st, t, last1;
  logic                       motion, spike, still, leading;
  logic [mks_pkg::TIME_W:0]   settle_sum, quiet_sum;
  logic [mks_pkg::TIME_W-1:0] settle_sat;

  assign pop = head_valid & (~out_valid_r | out_ch.ready);

  always_comb begin
    id     = head_word.fresh ? 1'b0 : initial_done_r;
    mp     = head_word.fresh ? 1'b0 : motion_pending_r;
    last_e = head_word.fresh ? '0 : last_emit_r;
    pt     = head_word.fresh ? '0 : prev_time_r;
    qt     = head_word.fresh ? '0 : quiet_r;
    st     = head_word.fresh ? '0 : settle_r;
    t      = head_word.frame_time;

    still  = head_word.prev_valid && head_word.count < cfg.still_count_limit;
    motion = ~still;
    spike  = head_word.prev_valid && !still && head_word.count > cfg.spike_count_limit;

    settle_sum = {1'b0, st} + (mks_pkg::TIME_W + 1)'(cfg.fine_step_cs);
    settle_sat = settle_sum[mks_pkg::TIME_W] ? mks_pkg::TIME_MAX
                                              : settle_sum[mks_pkg::TIME_W-1:0];

    kind_nxt           = mks_pkg::KIND_NONE;
    etime_nxt          = '0;
    initial_done_nxt   = id;
    motion_pending_nxt = mp;
    last_emit_nxt      = last_e;
    settle_nxt         = st;
    leading            = 1'b0;
    last1              = last_e;

    if (!id) begin
      kind_nxt         = mks_pkg::KIND_INITIAL;
      etime_nxt        = t;
      initial_done_nxt = 1'b1;
      last_emit_nxt    = t;
    end else if (spike && mp && pt != '0) begin
      if ({1'b0, pt} > {1'b0, last_e} + mks_pkg::MIN_GAP) begin
        kind_nxt      = mks_pkg::KIND_PRE_SPIKE;
        etime_nxt     = pt;
        last_emit_nxt = pt;
      end
      motion_pending_nxt = 1'b1;
    end else if (motion) begin
      leading = !mp && ({1'b0, t} > {1'b0, last_e} + mks_pkg::MIN_GAP);
      if (leading) begin
        kind_nxt      = mks_pkg::KIND_LEADING;
        etime_nxt     = t;
        last_emit_nxt = t;
        last1         = t;
      end
      motion_pending_nxt = 1'b1;
      if ({1'b0, t} > {1'b0, last1} + (mks_pkg::TIME_W + 1)'(cfg.burst_cap_cs)) begin
        kind_nxt      = mks_pkg::KIND_BURST;
        etime_nxt     = t;
        last_emit_nxt = t;
      end
    end else if (mp) begin
      settle_nxt = settle_sat;
      if (settle_sat >= mks_pkg::TIME_W'(cfg.settle_cs)) begin
        kind_nxt           = mks_pkg::KIND_SETTLED;
        etime_nxt          = t;
        motion_pending_nxt = 1'b0;
        settle_nxt         = '0;
        last_emit_nxt      = t;
      end
    end

    step_nxt = (qt >= mks_pkg::TIME_W'(cfg.coarse_delay_cs) && !motion_pending_nxt)
               ? mks_pkg::COARSE_STEP : cfg.fine_step_cs;
    quiet_sum = {1'b0, qt} + (mks_pkg::TIME_W + 1)'(step_nxt);
    if (motion) begin
      quiet_nxt  = '0;
      settle_nxt = '0;
    end else begin
      quiet_nxt = quiet_sum[mks_pkg::TIME_W] ? mks_pkg::TIME_MAX
                                              : quiet_sum[mks_pkg::TIME_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      initial_done_r   <= 1'b0;
      motion_pending_r <= 1'b0;
      last_emit_r      <= '0;
      prev_time_r      <= '0;
      quiet_r          <= '0;
      settle_r         <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      if (pop) begin
        initial_done_r   <= initial_done_nxt;
        motion_pending_r <= motion_pending_nxt;
        last_emit_r      <= last_emit_nxt;
        prev_time_r      <= t;
        quiet_r          <= quiet_nxt;
        settle_r         <= settle_nxt;
        out_valid_r      <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (pop) begin
      kind_r   <= kind_nxt;
      etime_r  <= etime_nxt;
      step_r   <= step_nxt;
      count_r  <= head_word.count;
      motion_r <= motion;
      spike_r  <= spike;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.emit_kind     = kind_r;
  assign out_ch.emit_time_cs  = etime_r;
  assign out_ch.next_step_cs  = step_r;
  assign out_ch.changed_count = count_r;
  assign out_ch.motion_seen   = motion_r;
  assign out_ch.spike_seen    = spike_r;

endmodule

// ===== design/mks_checker.sv =====
`include "motion_keyframe_selector_assert.svh"

module mks_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [mks_pkg::KIND_W-1:0]       emit_kind,
  input logic [mks_pkg::TIME_W-1:0]       emit_time_cs,
  input logic [mks_pkg::CNT_W-1:0]        changed_count,
  input logic                             motion_seen,
  input logic                             spike_seen
);

  `MKS_ASSERT_NEXT(a_stall_holds, clk, rst_n, out_valid && !out_ready, out_valid && $stable(emit_kind) && $stable(emit_time_cs) && $stable(changed_count))
  `MKS_ASSERT_SAME(a_kind_known, clk, rst_n, out_valid, emit_kind <= mks_pkg::KIND_SETTLED)
  `MKS_ASSERT_SAME(a_none_zero_time, clk, rst_n, out_valid && emit_kind == mks_pkg::KIND_NONE, emit_time_cs == '0)
  `MKS_ASSERT_SAME(a_spike_is_motion, clk, rst_n, out_valid && spike_seen, motion_seen && emit_kind != mks_pkg::KIND_SETTLED)

endmodule

bind motion_keyframe_selector mks_checker u_mks_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .emit_kind     (out_ch.emit_kind),
  .emit_time_cs  (out_ch.emit_time_cs),
  .changed_count (out_ch.changed_count),
  .motion_seen   (out_ch.motion_seen),
  .spike_seen    (out_ch.spike_seen)
);

// ===== test/tb.sv =====
module tb;

  typedef struct packed {
    logic [mks_pkg::PIX_W-1:0]  pixel;
    logic                       last;
    logic                       fresh;
    logic [mks_pkg::TIME_W-1:0] stamp;
  } pixel_word_t;

  typedef struct packed {
    mks_pkg::emit_kind_t        kind;
    logic [mks_pkg::TIME_W-1:0] stamp;
    logic [mks_pkg::STEP_W-1:0] step;
    logic [mks_pkg::CNT_W-1:0]  count;
    logic                       motion;
    logic                       spike;
  } keyframe_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_we = 1'b0;
  logic [mks_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [mks_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  mks_in_if  pix_if();
  mks_out_if kf_if();

  motion_keyframe_selector i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (pix_if),
    .out_ch    (kf_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  pixel_word_t pixel_q[$];
  keyframe_t   keyframe_q[$];
  int          mismatches = 0;
  int          send_idle_pct = 34;
  int          stall_pct = 67;
  bit          want_hold = 1'b0;
  bit          hold_done = 1'b0;
  int          hold_left = 0;

  // predictor state
  mks_pkg::cfg_t             cur_cfg;
  logic [mks_pkg::PIX_W-1:0] seen_px [mks_pkg::MAX_PIXELS];
  bit                        primed = 1'b0;
  bit                        opened = 1'b0;
  bit                        motion_open = 1'b0;
  longint                    emit_at = 0;
  longint                    prior_at = 0;
  longint                    quiet_cs = 0;
  longint                    settle_acc = 0;
  int unsigned               chg_cnt = 0;
  int unsigned               px_addr = 0;

  // generator mirror of what has been sent
  logic [mks_pkg::PIX_W-1:0] sent_px [mks_pkg::MAX_PIXELS];
  int                        gen_addr = 0;
  int                        gen_hw = 0;
  int                        gen_thr = 25;
  longint                    gen_t = 0;

  pixel_word_t next_word;
  pixel_word_t taken_word;
  keyframe_t   want;
  keyframe_t   outcome;

  always #5 clk = ~clk;

  function automatic longint clip24(longint v);
    return (v > mks_pkg::TIME_MAX) ? longint'(mks_pkg::TIME_MAX) : v;
  endfunction

  function automatic bit predict_keyframe(input pixel_word_t w, output keyframe_t k);
    int unsigned gap;
    int unsigned step;
    bit          moving;
    bit          spiking;
    longint      stamp;
    k = '0;
    k.kind = mks_pkg::KIND_NONE;
    moving = 1'b1;
    spiking = 1'b0;
    stamp = w.stamp;
    if (px_addr == 0 && w.fresh) begin
      primed = 1'b0;
      opened = 1'b0;
      motion_open = 1'b0;
      emit_at = 0;
      prior_at = 0;
      quiet_cs = 0;
      settle_acc = 0;
    end
    if (px_addr < mks_pkg::MAX_PIXELS) begin
      if (primed) begin
        gap = (w.pixel > seen_px[px_addr]) ? w.pixel - seen_px[px_addr]
                                           : seen_px[px_addr] - w.pixel;
        if (gap > cur_cfg.diff_threshold && chg_cnt < mks_pkg::CNT_MAX) chg_cnt++;
      end
      seen_px[px_addr] = w.pixel;
      px_addr++;
    end
    if (!w.last) return 1'b0;

    if (primed) begin
      if (chg_cnt < cur_cfg.still_count_limit) moving = 1'b0;
      else if (chg_cnt > cur_cfg.spike_count_limit) spiking = 1'b1;
    end

    if (!opened) begin
      k.kind = mks_pkg::KIND_INITIAL;
      k.stamp = w.stamp;
      opened = 1'b1;
      emit_at = stamp;
    end else if (spiking && motion_open && prior_at > 0) begin
      if (prior_at > emit_at + mks_pkg::MIN_GAP) begin
        k.kind = mks_pkg::KIND_PRE_SPIKE;
        k.stamp = prior_at[mks_pkg::TIME_W-1:0];
        emit_at = prior_at;
      end
      motion_open = 1'b1;
    end else if (moving) begin
      if (!motion_open && stamp > emit_at + mks_pkg::MIN_GAP) begin
        k.kind = mks_pkg::KIND_LEADING;
        k.stamp = w.stamp;
        emit_at = stamp;
      end
      motion_open = 1'b1;
      if (stamp - emit_at > longint'(cur_cfg.burst_cap_cs)) begin
        k.kind = mks_pkg::KIND_BURST;
        k.stamp = w.stamp;
        emit_at = stamp;
      end
    end else if (motion_open) begin
      settle_acc = clip24(settle_acc + cur_cfg.fine_step_cs);
      if (settle_acc >= cur_cfg.settle_cs) begin
        k.kind = mks_pkg::KIND_SETTLED;
        k.stamp = w.stamp;
        motion_open = 1'b0;
        settle_acc = 0;
        emit_at = stamp;
      end
    end

    prior_at = stamp;
    step = (quiet_cs >= cur_cfg.coarse_delay_cs && !motion_open) ? mks_pkg::COARSE_STEP
                                                                 : cur_cfg.fine_step_cs;
    if (moving) begin
      quiet_cs = 0;
      settle_acc = 0;
    end else begin
      quiet_cs = clip24(quiet_cs + step);
    end
    primed = 1'b1;

    k.step = step[mks_pkg::STEP_W-1:0];
    k.count = chg_cnt[mks_pkg::CNT_W-1:0];
    k.motion = moving;
    k.spike = spiking;
    chg_cnt = 0;
    px_addr = 0;
    return 1'b1;
  endfunction

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endfunction

  // pixel driver
  always @(posedge clk) begin
    if (!rst_n) begin
      pix_if.valid <= 1'b0;
      pix_if.pixel <= '0;
      pix_if.last_pixel <= 1'b0;
      pix_if.new_chunk <= 1'b0;
      pix_if.frame_time_cs <= '0;
    end else if (!pix_if.valid || pix_if.ready) begin
      if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_word = pixel_q.pop_front();
        pix_if.valid <= 1'b1;
        pix_if.pixel <= next_word.pixel;
        pix_if.last_pixel <= next_word.last;
        pix_if.new_chunk <= next_word.fresh;
        pix_if.frame_time_cs <= next_word.stamp;
      end else begin
        pix_if.valid <= 1'b0;
      end
    end
  end

  // result backpressure
  always @(posedge clk) begin
    if (hold_left != 0) begin
      kf_if.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (want_hold && !hold_done) begin
      kf_if.ready <= 1'b0;
      hold_left <= 400;
      hold_done <= 1'b1;
    end else begin
      kf_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // monitor: check results, then predict from the accepted pixel word
  always @(posedge clk) begin
    if (rst_n) begin
      if (kf_if.valid && kf_if.ready) begin
        if (keyframe_q.size() == 0) begin
          note_mismatch($sformatf("unexpected result word kind=%0d time=%0d count=%0d",
                                  kf_if.emit_kind, kf_if.emit_time_cs, kf_if.changed_count));
        end else begin
          want = keyframe_q.pop_front();
          if (kf_if.emit_kind !== want.kind || kf_if.emit_time_cs !== want.stamp ||
              kf_if.next_step_cs !== want.step || kf_if.changed_count !== want.count ||
              kf_if.motion_seen !== want.motion || kf_if.spike_seen !== want.spike)
            note_mismatch({
              $sformatf("expected kind=%0d time=%0d step=%0d count=%0d motion=%0d spike=%0d",
                        want.kind, want.stamp, want.step, want.count, want.motion,
                        want.spike),
              $sformatf(", got kind=%0d time=%0d step=%0d count=%0d motion=%0d spike=%0d",
                        kf_if.emit_kind, kf_if.emit_time_cs, kf_if.next_step_cs,
                        kf_if.changed_count, kf_if.motion_seen, kf_if.spike_seen)});
        end
      end
      if (pix_if.valid && pix_if.ready) begin
        taken_word.pixel = pix_if.pixel;
        taken_word.last = pix_if.last_pixel;
        taken_word.fresh = pix_if.new_chunk;
        taken_word.stamp = pix_if.frame_time_cs;
        if (predict_keyframe(taken_word, outcome)) begin
          keyframe_q.insert(keyframe_q.size(), outcome);
        end
      end
    end
  end

  task automatic set_reg(mks_pkg::cfg_index_t idx, int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[mks_pkg::CFG_DATA_W-1:0];
    case (idx)
      mks_pkg::CFG_DIFF_THRESHOLD: begin
        cur_cfg.diff_threshold = val[mks_pkg::PIX_W-1:0];
        gen_thr = int'(val[mks_pkg::PIX_W-1:0]);
      end
      mks_pkg::CFG_STILL_LIMIT:  cur_cfg.still_count_limit = val[mks_pkg::CNT_W-1:0];
      mks_pkg::CFG_SPIKE_LIMIT:  cur_cfg.spike_count_limit = val[mks_pkg::CNT_W-1:0];
      mks_pkg::CFG_FINE_STEP:    cur_cfg.fine_step_cs = val[mks_pkg::STEP_W-1:0];
      mks_pkg::CFG_COARSE_DELAY: cur_cfg.coarse_delay_cs = val[mks_pkg::LIM_W-1:0];
      mks_pkg::CFG_BURST_CAP:    cur_cfg.burst_cap_cs = val[mks_pkg::LIM_W-1:0];
      mks_pkg::CFG_SETTLE:       cur_cfg.settle_cs = val[mks_pkg::LIM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(int unsigned thr, int unsigned still, int unsigned spike,
                               int unsigned fine, int unsigned coarse, int unsigned burst,
                               int unsigned settle);
    set_reg(mks_pkg::CFG_DIFF_THRESHOLD, thr);
    set_reg(mks_pkg::CFG_STILL_LIMIT, still);
    set_reg(mks_pkg::CFG_SPIKE_LIMIT, spike);
    set_reg(mks_pkg::CFG_FINE_STEP, fine);
    set_reg(mks_pkg::CFG_COARSE_DELAY, coarse);
    set_reg(mks_pkg::CFG_BURST_CAP, burst);
    set_reg(mks_pkg::CFG_SETTLE, settle);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic push_px(int px, bit last, bit fresh, longint stamp);
    pixel_word_t w;
    w.pixel = mks_pkg::PIX_W'(px);
    w.last = last;
    w.fresh = (gen_addr == 0) ? fresh : bit'($urandom_range(1));
    w.stamp = last ? stamp[mks_pkg::TIME_W-1:0] : mks_pkg::TIME_W'($urandom);
    pixel_q.insert(pixel_q.size(), w);
    if (gen_addr < mks_pkg::MAX_PIXELS) begin
      sent_px[gen_addr] = mks_pkg::PIX_W'(px);
      if (gen_addr + 1 > gen_hw) gen_hw = gen_addr + 1;
    end
    gen_addr = last ? 0 : gen_addr + 1;
  endtask

  task automatic pair_frame(int p0, int p1, bit fresh, longint stamp);
    push_px(p0, 1'b0, fresh, stamp);
    push_px(p1, 1'b1, fresh, stamp);
  endtask

  task automatic queue_frames(int n_words);
    int len;
    int chg;
    int base;
    int delta;
    int px;
    int pushed;
    bit fresh;
    pushed = 0;
    while (pushed < n_words) begin
      len = ($urandom_range(4) == 0) ? $urandom_range(16, 9) : $urandom_range(8, 1);
      fresh = ($urandom_range(24) == 0) || (len > gen_hw);
      case ($urandom_range(3))
        0: chg = 0;
        1: chg = 8;
        2: chg = 35;
        default: chg = 100;
      endcase
      case ($urandom_range(19))
        0: gen_t = $urandom_range(mks_pkg::TIME_MAX);
        1: gen_t = gen_t - $urandom_range(int'(gen_t));
        2, 3: gen_t = gen_t + $urandom_range(3000);
        default: gen_t = gen_t + $urandom_range(60);
      endcase
      gen_t = clip24(gen_t);
      for (int a = 0; a < len; a++) begin
        base = (a < gen_hw) ? int'(sent_px[a]) : int'($urandom_range(255));
        if ($urandom_range(99) < chg) begin
          px = $urandom_range(255);
        end else if ($urandom_range(9) == 0) begin
          // land right on or just past the threshold
          delta = gen_thr + $urandom_range(1);
          px = (base + delta <= 255) ? base + delta : ((base >= delta) ? base - delta : base);
        end else begin
          px = base;
        end
        push_px(px, a == len - 1, fresh, gen_t);
      end
      pushed += len;
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (pixel_q.size() != 0 || pix_if.valid || keyframe_q.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: every emission kind but pre-spike, threshold edge, time extremes, time going back
    load_settings(25, 1, 1, 10, 20, 50, 10);
    pair_frame(0, 255, 1'b1, 0);
    pair_frame(0, 255, 1'b0, 10);
    pair_frame(26, 255, 1'b0, 20);
    pair_frame(51, 230, 1'b0, 30);
    pair_frame(77, 230, 1'b0, 40);
    pair_frame(255, 0, 1'b0, 50);
    pair_frame(255, 0, 1'b0, 200);
    pair_frame(0, 0, 1'b0, 260);
    pair_frame(26, 0, 1'b0, 400);
    pair_frame(26, 0, 1'b0, mks_pkg::TIME_MAX);
    pair_frame(255, 0, 1'b0, 3);
    pair_frame(255, 0, 1'b1, 100);
    gen_t = 100;
    wait_idle();

    load_settings(25, 2, 6, 10, 300, 100, 30);
    queue_frames(140);
    wait_idle();

    send_idle_pct = 67;
    stall_pct = 34;
    load_settings(0, 0, 0, 1, 0, 0, 0);
    queue_frames(140);
    wait_idle();

    load_settings(255, 262144, 262144, 1000, 60000, 60000, 60000);
    queue_frames(140);
    wait_idle();

    send_idle_pct = 0;
    stall_pct = 0;
    load_settings($urandom_range(80), $urandom_range(4, 1), $urandom_range(12, 3), 0,
                  $urandom_range(500), $urandom_range(200), $urandom_range(60));
    want_hold = 1'b1;
    queue_frames(140);
    wait_idle();

    load_settings($urandom_range(60), $urandom_range(5), $urandom_range(14),
                  $urandom_range(1000, 1), $urandom_range(60000), $urandom_range(400),
                  $urandom_range(2000));
    queue_frames(140);
    wait_idle();

    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("tb NOT OK");
    $finish;
  end

endmodule
